>>> sv/generational_slot_map_core_assert.svh
// Assertion macros shared by the slot map modules.
// Needs no other file; the bodies are empty in synthesis builds.
`ifndef GENERATIONAL_SLOT_MAP_CORE_ASSERT_SVH
`define GENERATIONAL_SLOT_MAP_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define GSM_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("slot map assertion failed");
`define GSM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slot map assertion failed");
`define GSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slot map assertion failed");
`else
`define GSM_ASSERT_ALWAYS(label, clk, rst, cond)
`define GSM_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define GSM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> sv/gsm_pkg.sv
// Shared types and constants of the generational slot map.
// Used by the controller, the datapath and the top level; depends on nothing.
package gsm_pkg;

   localparam int GSM_CAPACITY   = 256;
   localparam int GSM_DATA_WIDTH = 32;
   localparam int GSM_GEN_WIDTH  = 16;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_GET    = 2'd2;
   localparam logic [1:0] MODE_UPDATE = 2'd3;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_BAD  = 2'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  handle_index;
      logic [15:0] handle_generation;
      logic [31:0] data_in;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  out_index;
      logic [15:0] out_generation;
      logic [31:0] read_data;
      logic [8:0]  live_count;
   } rsp_payload_type;

   typedef struct packed {
      logic clear_step;
      logic accept;
      logic dense_rd;
      logic ins_commit;
      logic upd_write;
      logic move_write;
      logic free_commit;
      logic rsp_ok;
      logic rsp_full;
      logic rsp_bad;
      logic rsp_get;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       full;
      logic       handle_ok;
      logic       need_move;
      logic       clear_last;
   } dpath_status_type;

endpackage

>>> sv/gsm_dpath.sv
// Datapath of the slot map: slot and dense memories, free list head, count and result register.
// Depends on gsm_pkg and the assertion macro header.
`include "generational_slot_map_core_assert.svh"

module gsm_dpath
   import gsm_pkg::*;
#(
   parameter int CAPACITY   = GSM_CAPACITY,
   parameter int DATA_WIDTH = GSM_DATA_WIDTH,
   parameter int GEN_WIDTH  = GSM_GEN_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  req_payload_type  req_payload,
   input  ctrl_cmd_type     cmd,
   output dpath_status_type status,
   output logic             rsp_strobe,
   output rsp_payload_type  rsp_payload
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]      slot_link_mem  [CAPACITY];
   logic [GEN_WIDTH-1:0]  slot_gen_mem   [CAPACITY];
   logic                  slot_live_mem  [CAPACITY];
   logic [DATA_WIDTH-1:0] dense_val_mem  [CAPACITY];
   logic [IDX_W-1:0]      dense_own_mem  [CAPACITY];

   req_payload_type       req_ff;
   logic [CNT_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      clr_ff;
   logic [CNT_W-1:0]      slot_link_q;
   logic [GEN_WIDTH-1:0]  slot_gen_q;
   logic                  slot_live_q;
   logic [DATA_WIDTH-1:0] dval_q;
   logic [IDX_W-1:0]      downer_q;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_ff, rsp_in;

   logic [31:0]           port_idx_w, idx_w, head_w, gen_w, cnt_w;
   logic [63:0]           dval_w;
   logic [IDX_W-1:0]      slot_rd_a, idx_a, head_a, count_a, pos_a, last_a, dense_rd_a;
   logic [CNT_W-1:0]      last_c, cap_c;
   logic [GEN_WIDTH-1:0]  gen_new;
   logic [DATA_WIDTH-1:0] data_conv;

   logic                  link_we, gen_we, live_we, dval_we, down_we;
   logic [IDX_W-1:0]      link_wa, gen_wa, live_wa, dval_wa, down_wa;
   logic [CNT_W-1:0]      link_wd;
   logic [GEN_WIDTH-1:0]  gen_wd;
   logic                  live_wd;
   logic [DATA_WIDTH-1:0] dval_wd;
   logic [IDX_W-1:0]      down_wd;

   always_comb begin
      port_idx_w = 32'(req_payload.handle_index);
      idx_w      = 32'(req_ff.handle_index);
      cap_c      = CNT_W'(CAPACITY);
      head_a     = head_ff[IDX_W-1:0];
      idx_a      = idx_w[IDX_W-1:0];
      count_a    = count_ff[IDX_W-1:0];
      pos_a      = slot_link_q[IDX_W-1:0];
      last_c     = count_ff - CNT_W'(1);
      last_a     = last_c[IDX_W-1:0];
      gen_new    = slot_gen_q + GEN_WIDTH'(1);
      data_conv  = DATA_WIDTH'(64'(req_ff.data_in));
      slot_rd_a  = (req_payload.mode == MODE_INSERT) ? head_a : port_idx_w[IDX_W-1:0];
      dense_rd_a = (req_ff.mode == MODE_REMOVE) ? last_a : pos_a;

      status.mode       = req_ff.mode;
      status.full       = (head_ff >= cap_c) || (count_ff >= cap_c);
      status.handle_ok  = (idx_w < 32'(CAPACITY)) && slot_live_q && (slot_link_q < cap_c)
                          && (slot_gen_q == GEN_WIDTH'(32'(req_ff.handle_generation)));
      status.need_move  = (count_ff != '0) && (slot_link_q != last_c);
      status.clear_last = (clr_ff == IDX_W'(CAPACITY - 1));
   end

   always_comb begin
      link_we = 1'b0;
      link_wa = clr_ff;
      link_wd = CNT_W'(clr_ff) + CNT_W'(1);
      gen_we  = 1'b0;
      gen_wa  = clr_ff;
      gen_wd  = '0;
      live_we = 1'b0;
      live_wa = clr_ff;
      live_wd = 1'b0;
      dval_we = 1'b0;
      dval_wa = pos_a;
      dval_wd = data_conv;
      down_we = 1'b0;
      down_wa = pos_a;
      down_wd = downer_q;
      if (cmd.clear_step) begin
         link_we = 1'b1;
         gen_we  = 1'b1;
         live_we = 1'b1;
      end
      if (cmd.ins_commit) begin
         link_we = 1'b1;
         link_wa = head_a;
         link_wd = count_ff;
         gen_we  = 1'b1;
         gen_wa  = head_a;
         gen_wd  = gen_new;
         live_we = 1'b1;
         live_wa = head_a;
         live_wd = 1'b1;
         dval_we = 1'b1;
         dval_wa = count_a;
         down_we = 1'b1;
         down_wa = count_a;
         down_wd = head_a;
      end
      if (cmd.upd_write) begin
         dval_we = 1'b1;
      end
      if (cmd.move_write) begin
         link_we = 1'b1;
         link_wa = downer_q;
         link_wd = slot_link_q;
         dval_we = 1'b1;
         dval_wd = dval_q;
         down_we = 1'b1;
      end
      if (cmd.free_commit) begin
         link_we = 1'b1;
         link_wa = idx_a;
         link_wd = head_ff;
         live_we = 1'b1;
         live_wa = idx_a;
         live_wd = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         slot_link_mem[link_wa] <= link_wd;
      end
      if (gen_we) begin
         slot_gen_mem[gen_wa] <= gen_wd;
      end
      if (live_we) begin
         slot_live_mem[live_wa] <= live_wd;
      end
      if (cmd.accept) begin
         slot_link_q <= slot_link_mem[slot_rd_a];
         slot_gen_q  <= slot_gen_mem[slot_rd_a];
         slot_live_q <= slot_live_mem[slot_rd_a];
      end
   end

   always_ff @(posedge clock) begin
      if (dval_we) begin
         dense_val_mem[dval_wa] <= dval_wd;
      end
      if (down_we) begin
         dense_own_mem[down_wa] <= down_wd;
      end
      if (cmd.dense_rd) begin
         dval_q   <= dense_val_mem[dense_rd_a];
         downer_q <= dense_own_mem[dense_rd_a];
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.ins_commit) begin
         head_in  = slot_link_q;
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.free_commit) begin
         head_in  = CNT_W'(idx_w);
         count_in = count_ff - CNT_W'(1);
      end
      head_w = 32'(head_ff);
      gen_w  = 32'(gen_new);
      cnt_w  = 32'(count_in);
      dval_w = 64'(dval_q);

      rsp_valid_in = cmd.ins_commit | cmd.free_commit | cmd.rsp_ok | cmd.rsp_full
                     | cmd.rsp_bad | cmd.rsp_get;
      rsp_in.status         = cmd.rsp_full ? STATUS_FULL :
                              (cmd.rsp_bad ? STATUS_BAD : STATUS_OK);
      rsp_in.out_index      = cmd.ins_commit ? head_w[7:0] : 8'd0;
      rsp_in.out_generation = cmd.ins_commit ? gen_w[15:0] : 16'd0;
      rsp_in.read_data      = cmd.rsp_get ? dval_w[31:0] : 32'd0;
      rsp_in.live_count     = cnt_w[8:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_payload;
      end
      if (rsp_valid_in) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `GSM_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= cap_c)
   `GSM_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid_ff, !rsp_valid_ff)
   `GSM_ASSERT_IMPLY(a_count_with_rsp, clock, reset,
      !$past(reset) && (count_ff != $past(count_ff)), rsp_valid_ff)

endmodule

>>> sv/gsm_ctrl.sv
// Controller of the slot map: sequences the clearing pass and each transaction.
// Depends on gsm_pkg and the assertion macro header.
`include "generational_slot_map_core_assert.svh"

module gsm_ctrl
   import gsm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  dpath_status_type status,
   output ctrl_cmd_type     cmd,
   output logic             busy
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_MOVE,
      ST_FREE,
      ST_GET
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = ST_IDLE;
            if (status.mode == MODE_INSERT) begin
               if (status.full) begin
                  cmd.rsp_full = 1'b1;
               end else begin
                  cmd.ins_commit = 1'b1;
               end
            end else if (!status.handle_ok) begin
               cmd.rsp_bad = 1'b1;
            end else begin
               case (status.mode)
                  MODE_REMOVE: begin
                     if (status.need_move) begin
                        cmd.dense_rd = 1'b1;
                        state_in     = ST_MOVE;
                     end else begin
                        cmd.free_commit = 1'b1;
                     end
                  end
                  MODE_GET: begin
                     cmd.dense_rd = 1'b1;
                     state_in     = ST_GET;
                  end
                  default: begin
                     cmd.upd_write = 1'b1;
                     cmd.rsp_ok    = 1'b1;
                  end
               endcase
            end
         end
         ST_MOVE: begin
            cmd.move_write = 1'b1;
            state_in       = ST_FREE;
         end
         ST_FREE: begin
            cmd.free_commit = 1'b1;
            state_in        = ST_IDLE;
         end
         ST_GET: begin
            cmd.rsp_get = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         busy_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   assign busy = busy_ff;

   `GSM_ASSERT_ALWAYS(a_busy_matches_state, clock, reset, busy_ff == (state_ff != ST_IDLE))
   `GSM_ASSERT_ALWAYS(a_one_response, clock, reset, $onehot0({cmd.ins_commit, cmd.free_commit, cmd.rsp_ok, cmd.rsp_full, cmd.rsp_bad, cmd.rsp_get}))
   `GSM_ASSERT_NEXT(a_accept_checks, clock, reset, cmd.accept, state_ff == ST_CHECK)

endmodule

>>> sv/generational_slot_map_core.sv
// Generational slot map: insert, remove, get and update by (index, generation) handle.
// After reset, busy stays high while the slot tables are cleared.
// The strobe follows the check state for insert, update, remove without relocation and
// every failure, the get state for get, and the free state for remove with relocation,
// where the last dense element is read and then written into the hole.
// A new transaction is taken once busy falls, so one is handled at a time; results never stall.
module generational_slot_map_core
   import gsm_pkg::*;
#(
   parameter int CAPACITY   = GSM_CAPACITY,
   parameter int DATA_WIDTH = GSM_DATA_WIDTH,
   parameter int GEN_WIDTH  = GSM_GEN_WIDTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_payload_type req_payload,
   output logic            rsp_strobe,
   output rsp_payload_type rsp_payload
);

   ctrl_cmd_type     cmd;
   dpath_status_type status;

   gsm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   gsm_dpath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH),
      .GEN_WIDTH  (GEN_WIDTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule
